// ----- rtl/ahp_pkg.sv -----
package ahp_pkg;

	// Default bound on the dimension count
	localparam int MAX_DIMS_DEFAULT = 8;

	// Fixed header layout
	localparam logic [7:0] ARR_BASE    = 8'h90;
	localparam int         HDR_ENTRIES = 5;
	localparam logic [7:0] TOP_MARKER  = ARR_BASE + 8'(HDR_ENTRIES);
	localparam logic [7:0] TAG_I64     = 8'hd3;
	localparam logic [7:0] TAG_I32     = 8'hd2;
	localparam logic [3:0] LEN_I64     = 4'd8;
	localparam logic [3:0] LEN_I32     = 4'd4;

	typedef enum logic [3:0] {
		PH_TOP        = 4'd0,
		PH_VERSION    = 4'd1,
		PH_NDIM       = 4'd2,
		PH_SHAPE_ARR  = 4'd3,
		PH_SHAPE_TAG  = 4'd4,
		PH_SHAPE_DATA = 4'd5,
		PH_PART_ARR   = 4'd6,
		PH_PART_TAG   = 4'd7,
		PH_PART_DATA  = 4'd8,
		PH_BLOCK_ARR  = 4'd9,
		PH_BLOCK_TAG  = 4'd10,
		PH_BLOCK_DATA = 4'd11,
		PH_DONE       = 4'd12
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SHAPE = 2'd0,
		KIND_PART  = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_ERR   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_TOP       = 3'd1,
		ERR_VERSION   = 3'd2,
		ERR_NDIM      = 3'd3,
		ERR_ARR       = 3'd4,
		ERR_TAG       = 3'd5,
		ERR_SHORT     = 3'd6,
		ERR_LONG      = 3'd7
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  dim_index;
		logic [63:0] value;
		err_t        error_code;
	} result_t;

endpackage

// ----- rtl/ahp_in_reg.sv -----
module ahp_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       last_s1
);

	// Take a new beat whenever the held one leaves or none is held
	assign byte_ready = !valid_s1 || advance;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	// Capture the payload on acceptance
	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

endmodule

// ----- rtl/ahp_parser.sv -----
module ahp_parser #(
	parameter int MAX_DIMS = ahp_pkg::MAX_DIMS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           byte_in,
	input  logic                 last_in,
	input  logic [6:0]           max_version,
	output logic                 res_valid,
	output ahp_pkg::result_t     res
);

	ahp_pkg::phase_t phase_q, phase_d;
	logic [3:0]      dim_count_q, dim_count_d;
	logic [3:0]      dim_counter_q, dim_counter_d;
	logic [3:0]      byte_counter_q, byte_counter_d;
	logic [63:0]     accum_q, accum_d;
	logic            discard_q, discard_d;

	ahp_pkg::err_t   code;
	logic            have_ext;
	ahp_pkg::kind_t  ext_kind;
	logic [63:0]     ext_val;
	logic [7:0]      marker;
	logic [3:0]      cnt_inc;
	logic [3:0]      bc_inc;
	logic [3:0]      data_len;
	logic            elem_end;
	logic            data_done;
	logic [63:0]     accum_shift;

	assign marker      = ahp_pkg::ARR_BASE + {4'd0, dim_count_q};
	assign cnt_inc     = dim_counter_q + 4'd1;
	assign elem_end    = cnt_inc >= dim_count_q;
	assign bc_inc      = byte_counter_q + 4'd1;
	assign data_len    = (phase_q == ahp_pkg::PH_SHAPE_DATA) ? ahp_pkg::LEN_I64
	                                                         : ahp_pkg::LEN_I32;
	assign data_done   = bc_inc >= data_len;
	assign accum_shift = {accum_q[55:0], byte_in};

	// Check one byte and work out the next parse state
	always_comb begin
		phase_d        = phase_q;
		dim_count_d    = dim_count_q;
		dim_counter_d  = dim_counter_q;
		byte_counter_d = byte_counter_q;
		accum_d        = accum_q;
		discard_d      = discard_q;
		code           = ahp_pkg::ERR_NONE;
		have_ext       = 1'b0;
		ext_kind       = ahp_pkg::KIND_SHAPE;
		ext_val        = accum_shift;
		res_valid      = 1'b0;
		res.kind       = ahp_pkg::KIND_ERR;
		res.dim_index  = 3'd0;
		res.value      = 64'd0;
		res.error_code = ahp_pkg::ERR_NONE;

		case (phase_q)
			ahp_pkg::PH_TOP: begin
				if (byte_in != ahp_pkg::TOP_MARKER) code = ahp_pkg::ERR_TOP;
				else phase_d = ahp_pkg::PH_VERSION;
			end
			ahp_pkg::PH_VERSION: begin
				if (byte_in > {1'b0, max_version}) code = ahp_pkg::ERR_VERSION;
				else phase_d = ahp_pkg::PH_NDIM;
			end
			ahp_pkg::PH_NDIM: begin
				if (byte_in > 8'(MAX_DIMS)) code = ahp_pkg::ERR_NDIM;
				else begin
					dim_count_d = byte_in[3:0];
					phase_d     = ahp_pkg::PH_SHAPE_ARR;
				end
			end
			ahp_pkg::PH_SHAPE_ARR: begin
				if (byte_in != marker) code = ahp_pkg::ERR_ARR;
				else begin
					dim_counter_d = 4'd0;
					phase_d = (dim_count_q == 4'd0) ? ahp_pkg::PH_PART_ARR
					                                : ahp_pkg::PH_SHAPE_TAG;
				end
			end
			ahp_pkg::PH_PART_ARR: begin
				if (byte_in != marker) code = ahp_pkg::ERR_ARR;
				else begin
					dim_counter_d = 4'd0;
					phase_d = (dim_count_q == 4'd0) ? ahp_pkg::PH_BLOCK_ARR
					                                : ahp_pkg::PH_PART_TAG;
				end
			end
			ahp_pkg::PH_BLOCK_ARR: begin
				if (byte_in != marker) code = ahp_pkg::ERR_ARR;
				else begin
					dim_counter_d = 4'd0;
					phase_d = (dim_count_q == 4'd0) ? ahp_pkg::PH_DONE
					                                : ahp_pkg::PH_BLOCK_TAG;
				end
			end
			ahp_pkg::PH_SHAPE_TAG: begin
				if (byte_in != ahp_pkg::TAG_I64) code = ahp_pkg::ERR_TAG;
				else begin
					byte_counter_d = 4'd0;
					phase_d        = ahp_pkg::PH_SHAPE_DATA;
				end
			end
			ahp_pkg::PH_PART_TAG: begin
				if (byte_in != ahp_pkg::TAG_I32) code = ahp_pkg::ERR_TAG;
				else begin
					byte_counter_d = 4'd0;
					phase_d        = ahp_pkg::PH_PART_DATA;
				end
			end
			ahp_pkg::PH_BLOCK_TAG: begin
				if (byte_in != ahp_pkg::TAG_I32) code = ahp_pkg::ERR_TAG;
				else begin
					byte_counter_d = 4'd0;
					phase_d        = ahp_pkg::PH_BLOCK_DATA;
				end
			end
			ahp_pkg::PH_SHAPE_DATA: begin
				accum_d        = accum_shift;
				byte_counter_d = data_done ? 4'd0 : bc_inc;
				if (data_done) begin
					have_ext      = 1'b1;
					ext_kind      = ahp_pkg::KIND_SHAPE;
					ext_val       = accum_shift;
					dim_counter_d = cnt_inc;
					phase_d = elem_end ? ahp_pkg::PH_PART_ARR : ahp_pkg::PH_SHAPE_TAG;
				end
			end
			ahp_pkg::PH_PART_DATA: begin
				accum_d        = accum_shift;
				byte_counter_d = data_done ? 4'd0 : bc_inc;
				if (data_done) begin
					have_ext      = 1'b1;
					ext_kind      = ahp_pkg::KIND_PART;
					ext_val       = {32'd0, accum_shift[31:0]};
					dim_counter_d = cnt_inc;
					phase_d = elem_end ? ahp_pkg::PH_BLOCK_ARR : ahp_pkg::PH_PART_TAG;
				end
			end
			ahp_pkg::PH_BLOCK_DATA: begin
				accum_d        = accum_shift;
				byte_counter_d = data_done ? 4'd0 : bc_inc;
				if (data_done) begin
					dim_counter_d = cnt_inc;
					phase_d = elem_end ? ahp_pkg::PH_DONE : ahp_pkg::PH_BLOCK_TAG;
				end
			end
			default: begin
				code = ahp_pkg::ERR_LONG;
			end
		endcase

		// Pick the result: error first, then end of message, then extent
		if (code != ahp_pkg::ERR_NONE) begin
			res_valid      = 1'b1;
			res.error_code = code;
		end else if (last_in) begin
			res_valid = 1'b1;
			if (phase_d == ahp_pkg::PH_DONE) begin
				res.kind  = ahp_pkg::KIND_DONE;
				res.value = {60'd0, dim_count_d};
			end else begin
				res.error_code = ahp_pkg::ERR_SHORT;
			end
		end else if (have_ext) begin
			res_valid     = 1'b1;
			res.kind      = ext_kind;
			res.dim_index = dim_counter_q[2:0];
			res.value     = ext_val;
		end

		// Restart on the last beat, drop the rest after an error
		if (code != ahp_pkg::ERR_NONE && !last_in) begin
			discard_d = 1'b1;
		end
		if (last_in) begin
			phase_d        = ahp_pkg::PH_TOP;
			dim_count_d    = 4'd0;
			dim_counter_d  = 4'd0;
			byte_counter_d = 4'd0;
			discard_d      = 1'b0;
		end

		// Dropped beats touch nothing but the discard flag, save that the last one restarts the parse
		if (discard_q) begin
			res_valid      = 1'b0;
			phase_d        = last_in ? ahp_pkg::PH_TOP : phase_q;
			dim_count_d    = last_in ? 4'd0 : dim_count_q;
			dim_counter_d  = last_in ? 4'd0 : dim_counter_q;
			byte_counter_d = last_in ? 4'd0 : byte_counter_q;
			accum_d        = accum_q;
			discard_d      = !last_in;
		end

		if (!step) begin
			res_valid = 1'b0;
		end
	end

	// Advance the parse state once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= ahp_pkg::PH_TOP;
			dim_count_q    <= 4'd0;
			dim_counter_q  <= 4'd0;
			byte_counter_q <= 4'd0;
			discard_q      <= 1'b0;
		end else if (step) begin
			phase_q        <= phase_d;
			dim_count_q    <= dim_count_d;
			dim_counter_q  <= dim_counter_d;
			byte_counter_q <= byte_counter_d;
			discard_q      <= discard_d;
		end
	end

	// Shift register for the extent bytes
	always_ff @(posedge clk) begin
		if (step) begin
			accum_q <= accum_d;
		end
	end

`ifndef SYNTH
	a_err_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == ahp_pkg::KIND_ERR |->
			res.value == 64'd0 && res.error_code != ahp_pkg::ERR_NONE)
		else $error("error beat with stray payload");

	a_code_only_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind != ahp_pkg::KIND_ERR |-> res.error_code == ahp_pkg::ERR_NONE)
		else $error("error code on a non-error beat");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_in |=> phase_q == ahp_pkg::PH_TOP && !discard_q)
		else $error("parser did not restart after the last beat");

	a_counter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ahp_pkg::PH_SHAPE_TAG || phase_q == ahp_pkg::PH_SHAPE_DATA ||
		 phase_q == ahp_pkg::PH_PART_TAG || phase_q == ahp_pkg::PH_PART_DATA ||
		 phase_q == ahp_pkg::PH_BLOCK_TAG || phase_q == ahp_pkg::PH_BLOCK_DATA)
		|-> dim_counter_q < dim_count_q)
		else $error("element counter ran past the dimension count");

	a_silent_discard: assert property (@(posedge clk) disable iff (!arst_n)
		discard_q |-> !res_valid)
		else $error("result emitted while discarding");
`endif

endmodule

// ----- rtl/array_header_parser.sv -----
// Datapath: a byte accepted into the input register is parsed and its result is captured in the result register.
// Throughput: one byte per cycle while result_ready is high; the parse state
// register is updated once per byte, so bytes never wait on each other.
// Reset: arst_n clears the parser to expect the top array marker, max_version to 0,
// and empties the input and result registers.
module array_header_parser #(
	parameter int MAX_DIMS = ahp_pkg::MAX_DIMS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_wdata,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [1:0]         kind,
	output logic [2:0]         dim_index,
	output logic signed [63:0] value,
	output logic [2:0]         error_code
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             advance;
	logic             res_valid;
	ahp_pkg::result_t res;
	ahp_pkg::result_t res_q;
	logic             out_valid_q;
	logic [6:0]       max_version_q;

	// Hold the configured version limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_version_q <= 7'd0;
		end else if (cfg_we) begin
			max_version_q <= cfg_wdata;
		end
	end

	// Parse a held beat once the result slot is free
	assign advance = valid_s1 && (!out_valid_q || result_ready);

	ahp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1),
		.last_s1    (last_s1)
	);

	ahp_parser #(
		.MAX_DIMS (MAX_DIMS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.byte_in     (byte_s1),
		.last_in     (last_s1),
		.max_version (max_version_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Result register: refill when empty or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_ready || !out_valid_q) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = res_q.kind;
	assign dim_index    = res_q.dim_index;
	assign value        = res_q.value;
	assign error_code   = res_q.error_code;

endmodule
